// ===== rtl/pcn_pkg.sv =====
// Shared codes for the primitive collision narrowphase block.
`default_nettype none
package pcn_pkg;

  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;
  localparam logic [1:0] SHAPE_PLANE  = 2'd2;
  localparam logic [1:0] SHAPE_NONE   = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/primitive_collision_narrowphase_top.sv =====
// Narrowphase contact test between a held body and a tested body, one shared multiplier.
// Load transaction: accepted while idle, gives no result, and leaves the block ready.
// Sphere-sphere test: squaring, bit-serial square root, range check; on a hit, bit-serial divides
//   give the normal per axis, then the contact point; Q16.16 at the default widths.
// Box-box: least-overlap axis; sphere or box vs plane: dot products, contact on a hit.
// One test at a time, a stalled result holds the block; reset leaves no held body, output empty.
`default_nettype none
module primitive_collision_narrowphase_top import pcn_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         cmd_i,
  input  wire  [1:0]                  shape_i,
  input  wire  signed [WORD_BITS-1:0] pos_x_i,
  input  wire  signed [WORD_BITS-1:0] pos_y_i,
  input  wire  signed [WORD_BITS-1:0] pos_z_i,
  input  wire  signed [WORD_BITS-1:0] size_x_i,
  input  wire  signed [WORD_BITS-1:0] size_y_i,
  input  wire  signed [WORD_BITS-1:0] size_z_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        colliding_o,
  output logic signed [WORD_BITS-1:0] normal_x_o,
  output logic signed [WORD_BITS-1:0] normal_y_o,
  output logic signed [WORD_BITS-1:0] normal_z_o,
  output logic signed [WORD_BITS-1:0] depth_o,
  output logic signed [WORD_BITS-1:0] contact_x_o,
  output logic signed [WORD_BITS-1:0] contact_y_o,
  output logic signed [WORD_BITS-1:0] contact_z_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int D1 = W + 1;
  localparam int XW = W + 3;
  localparam int PW = 2 * W + 2;
  localparam int RW = W + 4;
  localparam int QW = F + 1;
  localparam int IW = $clog2(W + 2);

  localparam logic signed [XW-1:0] WMAX_X = {{4{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X = {{4{1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] WMAX_P = {{(W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] WMIN_P = {{(W+3){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE_W  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0]  WMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN_W = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_SS_SQ   = 4'd2;
  localparam logic [3:0] S_SS_SQRT = 4'd3;
  localparam logic [3:0] S_SS_CHK  = 4'd4;
  localparam logic [3:0] S_SS_DIV  = 4'd5;
  localparam logic [3:0] S_SS_CON  = 4'd6;
  localparam logic [3:0] S_BX      = 4'd7;
  localparam logic [3:0] S_BX_SEL  = 4'd8;
  localparam logic [3:0] S_PL_MUL  = 4'd9;
  localparam logic [3:0] S_PL_EVAL = 4'd10;
  localparam logic [3:0] S_PL_CON  = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  function automatic logic signed [W-1:0] mulq(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] sh;
    sh = p >>> F;
    if (sh > WMAX_P) mulq = WMAX_W;
    else if (sh < WMIN_P) mulq = WMIN_W;
    else mulq = sh[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] satx(input logic signed [XW-1:0] v);
    if (v > WMAX_X) satx = WMAX_W;
    else if (v < WMIN_X) satx = WMIN_W;
    else satx = v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] negsat(input logic signed [W-1:0] v);
    if (v == WMIN_W) negsat = WMAX_W;
    else negsat = -v;
  endfunction

  function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
    sx = {{3{v[W-1]}}, v};
  endfunction

  function automatic logic signed [D1-1:0] s1(input logic signed [W-1:0] v);
    s1 = {v[W-1], v};
  endfunction

  logic [3:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;
  logic [IW-1:0] itc_q, itc_d;

  logic [1:0] hshape_q, hshape_d, bshape_q, bshape_d;
  logic signed [W-1:0] hpos_q [3], hpos_d [3], hsize_q [3], hsize_d [3];
  logic signed [W-1:0] bpos_q [3], bpos_d [3], bsize_q [3], bsize_d [3];

  logic signed [PW-1:0] prod_q;
  logic signed [D1-1:0] ma, mb;
  logic [PW-1:0] sq_q, sq_d, rad_q, rad_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [D1-1:0] root_q, root_d;
  logic [W+1:0]  drem_q, drem_d;
  logic [QW-1:0] quo_q, quo_d;

  logic hit_q, hit_d;
  logic signed [W-1:0]  n_q [3], n_d [3];
  logic signed [XW-1:0] rc_q [3], rc_d [3];
  logic signed [XW-1:0] ov_q [3], ov_d [3];
  logic                 dneg_q [3], dneg_d [3];
  logic signed [XW-1:0] depth_q, depth_d, r_q, r_d, acc_q, acc_d;
  logic signed [W-1:0]  dist_q, dist_d;

  logic out_valid_q, out_valid_d, coll_q, coll_d;
  logic signed [W-1:0] on_q [3], on_d [3], oc_q [3], oc_d [3], od_q, od_d;

  logic signed [D1-1:0] dlt [3];
  logic [D1-1:0]        dmag [3];
  logic                 a_plane;
  logic [1:0]           body;
  logic signed [W-1:0]  pn [3], ctr [3], sz [3], pnabs [3], off;
  logic signed [D1-1:0] sum_r;
  logic [1:0]           ii, ci;

  logic [RW-1:0]        rem_sh, trial;
  logic [W+1:0]         dsub;
  logic                 dge;
  logic [QW-1:0]        qfin;
  logic signed [W-1:0]  qw;
  logic signed [XW-1:0] ovx, la, lb, ua, ub, mx, mn, cs, distx, sumx, dd;
  logic signed [W-1:0]  distw;
  logic [1:0]           sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i]   = s1(hpos_q[i]) - s1(bpos_q[i]);
      dmag[i]  = dlt[i][D1-1] ? D1'(-dlt[i]) : D1'(dlt[i]);
      pn[i]    = a_plane ? hpos_q[i] : bpos_q[i];
      ctr[i]   = a_plane ? bpos_q[i] : hpos_q[i];
      sz[i]    = a_plane ? bsize_q[i] : hsize_q[i];
      pnabs[i] = pn[i][W-1] ? negsat(pn[i]) : pn[i];
    end
  end

  assign a_plane = (hshape_q == SHAPE_PLANE);
  assign body    = a_plane ? bshape_q : hshape_q;
  assign off     = a_plane ? hsize_q[0] : bsize_q[0];
  assign sum_r   = s1(hsize_q[0]) + s1(bsize_q[0]);
  assign ii      = (cnt_q >= 3'd3) ? 2'(cnt_q - 3'd3) : cnt_q[1:0];
  assign ci      = (cnt_q >= 3'd4) ? 2'(cnt_q - 3'd4) : 2'(cnt_q - 3'd1);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_SS_SQ: begin
        if (cnt_q < 3'd3) begin
          ma = dlt[ii];
          mb = dlt[ii];
        end
      end
      S_SS_CON: begin
        if (cnt_q < 3'd3) begin
          ma = s1(n_q[ii]);
          mb = s1(bsize_q[0]);
        end
      end
      S_PL_MUL: begin
        if (cnt_q < 3'd3) begin
          ma = s1(sz[ii]);
          mb = s1(pnabs[ii]);
        end else if (cnt_q < 3'd6) begin
          ma = s1(ctr[ii]);
          mb = s1(pn[ii]);
        end
      end
      S_PL_CON: begin
        if (cnt_q < 3'd3) begin
          ma = s1(pn[ii]);
          mb = s1(dist_q);
        end
      end
      default: ;
    endcase
  end

  assign rem_sh = {rem_q[RW-3:0], rad_q[PW-1:PW-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign dge    = drem_q >= {1'b0, root_q};
  assign dsub   = dge ? drem_q - {1'b0, root_q} : drem_q;
  assign qfin   = {quo_q[QW-2:0], dge};
  assign qw     = {{(W-QW){1'b0}}, qfin};
  assign distx  = {2'b00, root_q};
  assign sumx   = {{2{sum_r[D1-1]}}, sum_r};
  assign ovx    = sx(hsize_q[ax_q]) + sx(bsize_q[ax_q]) - {2'b00, dmag[ax_q]};
  assign la     = sx(hpos_q[ax_q]) - sx(hsize_q[ax_q]);
  assign lb     = sx(bpos_q[ax_q]) - sx(bsize_q[ax_q]);
  assign ua     = sx(hpos_q[ax_q]) + sx(hsize_q[ax_q]);
  assign ub     = sx(bpos_q[ax_q]) + sx(bsize_q[ax_q]);
  assign mx     = (la > lb) ? la : lb;
  assign mn     = (ua < ub) ? ua : ub;
  assign cs     = mx + mn;
  assign dd     = acc_q - sx(off);
  assign distw  = satx(dd);

  always_comb begin
    sel = 2'd0;
    if (ov_q[1] < ov_q[0]) sel = 2'd1;
    if (ov_q[2] < ov_q[sel]) sel = 2'd2;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ax_d = ax_q;
    itc_d = itc_q;
    hshape_d = hshape_q;
    bshape_d = bshape_q;
    hpos_d = hpos_q;
    hsize_d = hsize_q;
    bpos_d = bpos_q;
    bsize_d = bsize_q;
    sq_d = sq_q;
    rad_d = rad_q;
    rem_d = rem_q;
    root_d = root_q;
    drem_d = drem_q;
    quo_d = quo_q;
    hit_d = hit_q;
    n_d = n_q;
    rc_d = rc_q;
    ov_d = ov_q;
    dneg_d = dneg_q;
    depth_d = depth_q;
    r_d = r_q;
    acc_d = acc_q;
    dist_d = dist_q;
    out_valid_d = out_valid_q;
    coll_d = coll_q;
    on_d = on_q;
    oc_d = oc_q;
    od_d = od_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_LOAD) begin
            hshape_d = shape_i;
            hpos_d = '{pos_x_i, pos_y_i, pos_z_i};
            hsize_d = '{size_x_i, size_y_i, size_z_i};
          end else begin
            bshape_d = shape_i;
            bpos_d = '{pos_x_i, pos_y_i, pos_z_i};
            bsize_d = '{size_x_i, size_y_i, size_z_i};
            state_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        hit_d = 1'b0;
        n_d = '{default: '0};
        rc_d = '{default: '0};
        depth_d = '0;
        cnt_d = '0;
        ax_d = '0;
        if (hshape_q == SHAPE_SPHERE && bshape_q == SHAPE_SPHERE) begin
          sq_d = '0;
          state_d = S_SS_SQ;
        end else if (hshape_q == SHAPE_BOX && bshape_q == SHAPE_BOX) begin
          hit_d = 1'b1;
          state_d = S_BX;
        end else if ((hshape_q == SHAPE_PLANE &&
                      (bshape_q == SHAPE_SPHERE || bshape_q == SHAPE_BOX)) ||
                     (bshape_q == SHAPE_PLANE &&
                      (hshape_q == SHAPE_SPHERE || hshape_q == SHAPE_BOX))) begin
          r_d = (body == SHAPE_SPHERE) ? sx(sz[0]) : '0;
          acc_d = '0;
          state_d = S_PL_MUL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SS_SQ: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q != 3'd0) sq_d = sq_q + prod_q;
        if (cnt_q == 3'd3) begin
          rad_d = sq_q + prod_q;
          rem_d = '0;
          root_d = '0;
          itc_d = '0;
          state_d = S_SS_SQRT;
        end
      end
      S_SS_SQRT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          root_d = {root_q[D1-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          root_d = {root_q[D1-2:0], 1'b0};
        end
        itc_d = itc_q + 1'b1;
        if (itc_q == IW'(W)) state_d = S_SS_CHK;
      end
      S_SS_CHK: begin
        if (root_q != '0 && distx < sumx) begin
          hit_d = 1'b1;
          depth_d = sumx - distx;
          ax_d = '0;
          itc_d = '0;
          drem_d = {1'b0, dmag[0]};
          state_d = S_SS_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SS_DIV: begin
        drem_d = {dsub[W:0], 1'b0};
        quo_d = qfin;
        itc_d = itc_q + 1'b1;
        if (itc_q == IW'(F)) begin
          n_d[ax_q] = dlt[ax_q][D1-1] ? -qw : qw;
          itc_d = '0;
          if (ax_q == 2'd2) begin
            cnt_d = '0;
            state_d = S_SS_CON;
          end else begin
            ax_d = ax_q + 2'd1;
            drem_d = {1'b0, dmag[2'(ax_q + 2'd1)]};
          end
        end
      end
      S_SS_CON: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q != 3'd0) rc_d[ci] = sx(bpos_q[ci]) + sx(mulq(prod_q));
        if (cnt_q == 3'd3) state_d = S_DONE;
      end
      S_BX: begin
        ov_d[ax_q] = ovx;
        dneg_d[ax_q] = dlt[ax_q][D1-1];
        rc_d[ax_q] = cs >>> 1;
        if (ovx <= 0) hit_d = 1'b0;
        ax_d = ax_q + 2'd1;
        if (ax_q == 2'd2) state_d = S_BX_SEL;
      end
      S_BX_SEL: begin
        n_d[sel] = dneg_q[sel] ? -ONE_W : ONE_W;
        depth_d = ov_q[sel];
        state_d = S_DONE;
      end
      S_PL_MUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q >= 3'd1 && cnt_q <= 3'd3 && body == SHAPE_BOX) r_d = r_q + sx(mulq(prod_q));
        if (cnt_q >= 3'd4) acc_d = acc_q + sx(mulq(prod_q));
        if (cnt_q == 3'd6) state_d = S_PL_EVAL;
      end
      S_PL_EVAL: begin
        dist_d = distw;
        cnt_d = '0;
        if (sx(distw) < r_q) begin
          hit_d = 1'b1;
          depth_d = r_q - sx(distw);
          for (int i = 0; i < 3; i++) n_d[i] = a_plane ? negsat(pn[i]) : pn[i];
          state_d = S_PL_CON;
        end else begin
          state_d = S_DONE;
        end
      end
      S_PL_CON: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q != 3'd0) rc_d[ci] = sx(ctr[ci]) - sx(mulq(prod_q));
        if (cnt_q == 3'd3) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          coll_d = hit_q;
          od_d = hit_q ? satx(depth_q) : '0;
          for (int i = 0; i < 3; i++) begin
            on_d[i] = hit_q ? n_q[i] : '0;
            oc_d[i] = hit_q ? satx(rc_q[i]) : '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      hshape_q <= SHAPE_NONE;
      hpos_q <= '{default: '0};
      hsize_q <= '{default: '0};
      cnt_q <= '0;
      ax_q <= '0;
      itc_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      hshape_q <= hshape_d;
      hpos_q <= hpos_d;
      hsize_q <= hsize_d;
      cnt_q <= cnt_d;
      ax_q <= ax_d;
      itc_q <= itc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    bshape_q <= bshape_d;
    bpos_q <= bpos_d;
    bsize_q <= bsize_d;
    sq_q <= sq_d;
    rad_q <= rad_d;
    rem_q <= rem_d;
    root_q <= root_d;
    drem_q <= drem_d;
    quo_q <= quo_d;
    hit_q <= hit_d;
    n_q <= n_d;
    rc_q <= rc_d;
    ov_q <= ov_d;
    dneg_q <= dneg_d;
    depth_q <= depth_d;
    r_q <= r_d;
    acc_q <= acc_d;
    dist_q <= dist_d;
    coll_q <= coll_d;
    on_q <= on_d;
    oc_q <= oc_d;
    od_q <= od_d;
  end

  assign out_valid_o = out_valid_q;
  assign colliding_o = coll_q;
  assign normal_x_o  = on_q[0];
  assign normal_y_o  = on_q[1];
  assign normal_z_o  = on_q[2];
  assign depth_o     = od_q;
  assign contact_x_o = oc_q[0];
  assign contact_y_o = oc_q[1];
  assign contact_z_o = oc_q[2];

  a_test_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CMD_TEST) |=> !in_ready_o)
    else $error("ready held high after a test transaction");

  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && colliding_o) |-> (depth_o > 0))
    else $error("colliding result with non-positive depth");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !colliding_o) |-> (depth_o == 0 && normal_x_o == 0 &&
      normal_y_o == 0 && normal_z_o == 0 && contact_x_o == 0))
    else $error("non-colliding result carries nonzero values");

endmodule
`default_nettype wire

// ===== tb/sv/pcn_checker.sv =====
// Checker for the collision narrowphase block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pcn_checker import pcn_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_ready_i,
  input  wire               cmd_i,
  input  wire  [1:0]        shape_i,
  input  wire  signed [31:0] pos_x_i,
  input  wire  signed [31:0] pos_y_i,
  input  wire  signed [31:0] pos_z_i,
  input  wire  signed [31:0] size_x_i,
  input  wire  signed [31:0] size_y_i,
  input  wire  signed [31:0] size_z_i,
  input  wire               out_valid_i,
  input  wire               out_ready_i,
  input  wire               colliding_i,
  input  wire  signed [31:0] normal_x_i,
  input  wire  signed [31:0] normal_y_i,
  input  wire  signed [31:0] normal_z_i,
  input  wire  signed [31:0] depth_i,
  input  wire  signed [31:0] contact_x_i,
  input  wire  signed [31:0] contact_y_i,
  input  wire  signed [31:0] contact_z_i,
  output int                errors_o,
  output int                pending_o
);

  localparam int     FRAC = 16;
  localparam int     SLOTS = 8;
  localparam longint UNIT = 64'sd65536;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic        hit;
    logic [31:0] nx, ny, nz, dep, cx, cy, cz;
  } contact_t;

  contact_t contacts_q [SLOTS];
  logic [2:0] rd_ptr, wr_ptr;
  int count;
  logic [1:0] held_shape;
  longint held_pos[3], held_size[3];

  function automatic longint clamp(longint v);
    return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = a;
    p = p * b;
    p = p >>> FRAC;
    if (p > WMAX) return WMAX;
    if (p < WMIN) return WMIN;
    return longint'(p);
  endfunction

  function automatic longint isqrt(logic [127:0] s);
    logic [63:0] r, c;
    logic [127:0] cc;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      cc = c;
      cc = cc * cc;
      if (cc <= s) r = c;
    end
    return longint'(r);
  endfunction

  function automatic contact_t predict_contact(logic [1:0] sb_shape, longint pb[3], longint sb[3]);
    contact_t res;
    longint n[3], c[3], d[3], ov[3], pn[3], ctr[3], sz[3];
    longint dep, pdist, sum, m, q, r, off, la, lb, ua, ub;
    logic [127:0] sq, t;
    logic hit, a_plane;
    logic [1:0] body;
    int ax;
    hit = 0;
    dep = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = 0;
      c[i] = 0;
    end
    if (held_shape == SHAPE_SPHERE && sb_shape == SHAPE_SPHERE) begin
      sum = held_size[0] + sb[0];
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = held_pos[i] - pb[i];
        m = d[i] < 0 ? -d[i] : d[i];
        t = m;
        sq += t * t;
      end
      pdist = isqrt(sq);
      if (pdist > 0 && pdist < sum) begin
        hit = 1;
        for (int i = 0; i < 3; i++) begin
          m = d[i] < 0 ? -d[i] : d[i];
          q = (m << FRAC) / pdist;
          if (q > WMAX) q = WMAX;
          n[i] = d[i] < 0 ? -q : q;
          c[i] = pb[i] + qmul(n[i], sb[0]);
        end
        dep = sum - pdist;
      end
    end else if (held_shape == SHAPE_BOX && sb_shape == SHAPE_BOX) begin
      hit = 1;
      for (int i = 0; i < 3; i++) begin
        d[i] = held_pos[i] - pb[i];
        ov[i] = held_size[i] + sb[i] - (d[i] < 0 ? -d[i] : d[i]);
        if (ov[i] <= 0) hit = 0;
      end
      if (hit) begin
        ax = 0;
        if (ov[1] < ov[ax]) ax = 1;
        if (ov[2] < ov[ax]) ax = 2;
        n[ax] = d[ax] >= 0 ? UNIT : -UNIT;
        dep = ov[ax];
        for (int i = 0; i < 3; i++) begin
          la = held_pos[i] - held_size[i];
          lb = pb[i] - sb[i];
          ua = held_pos[i] + held_size[i];
          ub = pb[i] + sb[i];
          c[i] = ((la > lb ? la : lb) + (ua < ub ? ua : ub)) >>> 1;
        end
      end
    end else if ((held_shape == SHAPE_PLANE &&
                  (sb_shape == SHAPE_SPHERE || sb_shape == SHAPE_BOX)) ||
                 (sb_shape == SHAPE_PLANE &&
                  (held_shape == SHAPE_SPHERE || held_shape == SHAPE_BOX))) begin
      a_plane = held_shape == SHAPE_PLANE;
      body = a_plane ? sb_shape : held_shape;
      off = a_plane ? held_size[0] : sb[0];
      for (int i = 0; i < 3; i++) begin
        pn[i] = a_plane ? held_pos[i] : pb[i];
        ctr[i] = a_plane ? pb[i] : held_pos[i];
        sz[i] = a_plane ? sb[i] : held_size[i];
      end
      r = 0;
      pdist = 0;
      if (body == SHAPE_SPHERE) r = sz[0];
      else for (int i = 0; i < 3; i++) r += qmul(sz[i], pn[i] < 0 ? clamp(-pn[i]) : pn[i]);
      for (int i = 0; i < 3; i++) pdist += qmul(ctr[i], pn[i]);
      pdist = clamp(pdist - off);
      if (pdist < r) begin
        hit = 1;
        for (int i = 0; i < 3; i++) begin
          n[i] = a_plane ? clamp(-pn[i]) : pn[i];
          c[i] = ctr[i] - qmul(pn[i], pdist);
        end
        dep = r - pdist;
      end
    end
    res = '0;
    if (hit) begin
      res.hit = 1;
      res.nx = 32'(clamp(n[0]));
      res.ny = 32'(clamp(n[1]));
      res.nz = 32'(clamp(n[2]));
      res.dep = 32'(clamp(dep));
      res.cx = 32'(clamp(c[0]));
      res.cy = 32'(clamp(c[1]));
      res.cz = 32'(clamp(c[2]));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint pb[3], sb[3];
    contact_t want;
    logic [31:0] ev[8], av[8];
    string names[8];
    if (!rst_ni) begin
      held_shape = SHAPE_NONE;
      for (int i = 0; i < 3; i++) begin
        held_pos[i] = 0;
        held_size[i] = 0;
      end
      rd_ptr = '0;
      wr_ptr = '0;
      count = 0;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (count == 0) begin
          $display("%0t: unexpected result transaction, colliding %0d", $time, colliding_i);
          errors_o++;
        end else begin
          want = contacts_q[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          count--;
          names = '{"colliding", "normal_x", "normal_y", "normal_z", "depth",
                    "contact_x", "contact_y", "contact_z"};
          ev = '{32'(want.hit), want.nx, want.ny, want.nz, want.dep,
                 want.cx, want.cy, want.cz};
          av = '{32'(colliding_i), normal_x_i, normal_y_i, normal_z_i, depth_i,
                 contact_x_i, contact_y_i, contact_z_i};
          for (int i = 0; i < 8; i++) begin
            if (ev[i] !== av[i]) begin
              $display("%0t: %s expected %h actual %h", $time, names[i], ev[i], av[i]);
              errors_o++;
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pb = '{longint'(pos_x_i), longint'(pos_y_i), longint'(pos_z_i)};
        sb = '{longint'(size_x_i), longint'(size_y_i), longint'(size_z_i)};
        if (cmd_i == CMD_LOAD) begin
          held_shape = shape_i;
          held_pos = pb;
          held_size = sb;
        end else if (count == SLOTS) begin
          $display("%0t: too many results outstanding, expected at most %0d actual %0d",
                   $time, SLOTS, count + 1);
          errors_o++;
        end else begin
          contacts_q[wr_ptr] = predict_contact(shape_i, pb, sb);
          wr_ptr = wr_ptr + 3'd1;
          count++;
        end
      end
      pending_o = count;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, receiver stalls, watchdog and verdict for the narrowphase block.
`timescale 1ns / 1ps
module tb;
  import pcn_pkg::*;

  localparam logic signed [31:0] UNIT = 32'sh10000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0, cmd = CMD_LOAD;
  logic [1:0] shape = SHAPE_NONE;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, size_x = 0, size_y = 0, size_z = 0;
  wire in_ready, out_valid, colliding;
  wire signed [31:0] normal_x, normal_y, normal_z, depth, contact_x, contact_y, contact_z;
  int errors, pending, idle_pct = 0, stall_pct = 0, quiet = 0, sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  primitive_collision_narrowphase_top dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .shape_i(shape), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .size_x_i(size_x), .size_y_i(size_y), .size_z_i(size_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .colliding_o(colliding),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z), .depth_o(depth),
    .contact_x_o(contact_x), .contact_y_o(contact_y), .contact_z_o(contact_z)
  );

  pcn_checker u_check (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .shape_i(shape), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .size_x_i(size_x), .size_y_i(size_y), .size_z_i(size_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .colliding_i(colliding),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .normal_z_i(normal_z), .depth_i(depth),
    .contact_x_i(contact_x), .contact_y_i(contact_y), .contact_z_i(contact_z),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("primitive_collision_narrowphase_top verification failed");
      $finish;
    end
  end

  task automatic send(input logic c, input logic [1:0] s,
                      input logic signed [31:0] px, py, pz, sx, sy, sz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    shape <= s;
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    size_x <= sx;
    size_y <= sy;
    size_z <= sz;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic signed [31:0] near_val();
    return $signed(32'($urandom_range(0, 524288))) - 32'sd262144;
  endfunction

  function automatic logic signed [31:0] extent_val();
    if ($urandom_range(19) == 0) return -$signed(32'($urandom_range(0, 65536)));
    return $signed(32'($urandom_range(0, 196608)));
  endfunction

  function automatic logic [1:0] pick_shape();
    int k;
    k = $urandom_range(0, 19);
    return k < 6 ? SHAPE_SPHERE : k < 12 ? SHAPE_BOX : k < 19 ? SHAPE_PLANE : SHAPE_NONE;
  endfunction

  task automatic send_body(input logic c, input logic [1:0] s);
    logic signed [31:0] p[3];
    int ax;
    if ($urandom_range(9) == 0) begin
      send(1'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
    end else if (s == SHAPE_PLANE) begin
      if ($urandom_range(1)) begin
        p = '{0, 0, 0};
        ax = $urandom_range(2);
        p[ax] = $urandom_range(1) ? UNIT : -UNIT;
      end else begin
        p = '{near_val() >>> 2, near_val() >>> 2, near_val() >>> 2};
      end
      send(c, s, p[0], p[1], p[2], near_val(), $urandom, $urandom);
    end else begin
      send(c, s, near_val(), near_val(), near_val(), extent_val(), extent_val(), extent_val());
    end
  endtask

  task automatic random_phase(input int target);
    logic [1:0] a, b;
    int tests;
    while (sent < target) begin
      a = pick_shape();
      send_body(CMD_LOAD, a);
      tests = $urandom_range(1, 6);
      repeat (tests) begin
        if (a == SHAPE_PLANE) b = $urandom_range(9) < 8 ? 2'($urandom_range(1)) : pick_shape();
        else b = pick_shape();
        send_body(CMD_TEST, b);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(CMD_TEST, SHAPE_SPHERE, 0, 0, 0, UNIT, 0, 0);
    send(CMD_LOAD, SHAPE_SPHERE, 0, 0, 0, 2 * UNIT, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, UNIT, 0, 0, 2 * UNIT, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, 0, 0, 0, 2 * UNIT, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, 10 * UNIT, 3, -7, UNIT, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX);
    send(CMD_LOAD, SHAPE_SPHERE, SMAX, SMAX, SMAX, SMAX, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
    send(CMD_TEST, SHAPE_PLANE, SMIN, SMAX, SMIN, SMIN, 0, 0);
    send(CMD_LOAD, SHAPE_BOX, 0, 0, 0, 2 * UNIT, 2 * UNIT, 2 * UNIT);
    send(CMD_TEST, SHAPE_BOX, UNIT, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 2 * UNIT);
    send(CMD_TEST, SHAPE_BOX, -UNIT, UNIT / 2, 3 * UNIT, UNIT, UNIT, UNIT);
    send(CMD_TEST, SHAPE_BOX, 9 * UNIT, 0, 0, UNIT, UNIT, UNIT);
    send(CMD_TEST, SHAPE_BOX, 0, 0, 0, -UNIT, -3 * UNIT, -UNIT);
    send(CMD_TEST, SHAPE_PLANE, 0, UNIT, 0, 0, 0, 0);
    send(CMD_LOAD, SHAPE_PLANE, 0, UNIT, 0, UNIT, 0, 0);
    send(CMD_TEST, SHAPE_SPHERE, 0, UNIT / 2, 0, UNIT, 0, 0);
    send(CMD_TEST, SHAPE_BOX, 3, 0, -5, UNIT, UNIT, UNIT);
    send(CMD_TEST, SHAPE_PLANE, 0, UNIT, 0, 0, 0, 0);
    send(CMD_TEST, SHAPE_NONE, 0, 0, 0, UNIT, UNIT, UNIT);
    send(CMD_LOAD, SHAPE_PLANE, SMIN, SMAX, 0, SMIN, 0, 0);
    send(CMD_TEST, SHAPE_BOX, SMAX, SMIN, SMAX, SMAX, SMAX, SMAX);
    send(CMD_LOAD, SHAPE_NONE, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    send(CMD_TEST, SHAPE_SPHERE, 0, 0, 0, SMAX, 0, 0);
    random_phase(135);
    idle_pct = 76;
    random_phase(240);
    idle_pct = 0;
    stall_pct = 76;
    random_phase(345);
    idle_pct = 16;
    stall_pct = 16;
    random_phase(450);
    in_valid <= 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("primitive_collision_narrowphase_top verification clean");
    end else begin
      $display("primitive_collision_narrowphase_top verification failed");
    end
    $finish;
  end

endmodule

// ===== primitive_collision_narrowphase_top.f =====
rtl/pcn_pkg.sv
rtl/primitive_collision_narrowphase_top.sv
tb/sv/pcn_checker.sv
tb/sv/tb.sv
